>>> hdl/pit_pkg.sv
// ----------------------------------------------------------------------------
// pit_pkg
// Shared types and constants for the point-in-triangle test pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pit_pkg;

  localparam int unsigned NumEdges  = 3;
  localparam int unsigned NumAxes   = 3;
  localparam int unsigned PipeDepth = 6;
  localparam int unsigned TolWidth  = 32;

  typedef logic [TolWidth-1:0] tol_t;

endpackage

>>> hdl/point_in_triangle_test.sv
// ----------------------------------------------------------------------------
// point_in_triangle_test
// Same-side point-in-triangle test on signed fixed-point coordinates.
// Throughput: one transaction per cycle when the output is not stalled;
// six register stages, each stage holds when its successor is full and
// stalled, empty stages fill in.
// Cross and dot products are exact; 51x51 dot terms are split in halves.
// Reset clears all stage valid bits and the tolerance register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module point_in_triangle_test #(
  parameter int unsigned COORD_WIDTH = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  pit_pkg::tol_t                 cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [COORD_WIDTH-1:0] vertex_a_x_i,
  input  logic signed [COORD_WIDTH-1:0] vertex_a_y_i,
  input  logic signed [COORD_WIDTH-1:0] vertex_a_z_i,
  input  logic signed [COORD_WIDTH-1:0] vertex_b_x_i,
  input  logic signed [COORD_WIDTH-1:0] vertex_b_y_i,
  input  logic signed [COORD_WIDTH-1:0] vertex_b_z_i,
  input  logic signed [COORD_WIDTH-1:0] vertex_c_x_i,
  input  logic signed [COORD_WIDTH-1:0] vertex_c_y_i,
  input  logic signed [COORD_WIDTH-1:0] vertex_c_z_i,
  input  logic signed [COORD_WIDTH-1:0] point_x_i,
  input  logic signed [COORD_WIDTH-1:0] point_y_i,
  input  logic signed [COORD_WIDTH-1:0] point_z_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          inside_res_o
);

  import pit_pkg::*;

  localparam int unsigned DW  = COORD_WIDTH + 1;   // coordinate difference
  localparam int unsigned PW  = 2 * DW;            // cross product term
  localparam int unsigned CW  = PW + 1;            // cross product component
  localparam int unsigned LW  = (CW + 1) / 2;      // low half, unsigned
  localparam int unsigned HW  = CW - LW;           // high half, signed
  localparam int unsigned LLW = 2 * LW;
  localparam int unsigned MW  = LW + 1 + HW;
  localparam int unsigned HHW = 2 * HW;
  localparam int unsigned QW  = 2 * CW;            // dot product term
  localparam int unsigned SW  = QW + 3;            // dot sum plus tolerance

  // handshake
  logic [PipeDepth-1:0] valid_q;
  logic [PipeDepth-1:0] rdy;
  logic [PipeDepth-1:0] vld_in;

  always_comb begin
    rdy[PipeDepth-1] = ~valid_q[PipeDepth-1] | out_ready_i;
    for (int k = PipeDepth - 2; k >= 0; k--) begin
      rdy[k] = ~valid_q[k] | rdy[k+1];
    end
  end

  assign vld_in     = {valid_q[PipeDepth-2:0], in_valid_i};
  assign in_ready_o = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = 0; k < PipeDepth; k++) begin
        if (rdy[k]) begin
          valid_q[k] <= vld_in[k];
        end
      end
    end
  end

  // tolerance register
  tol_t tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= '0;
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  // edge k: start, end, opposite vertex
  logic signed [COORD_WIDTH-1:0] va [NumAxes];
  logic signed [COORD_WIDTH-1:0] vb [NumAxes];
  logic signed [COORD_WIDTH-1:0] vc [NumAxes];
  logic signed [COORD_WIDTH-1:0] vp [NumAxes];

  assign va[0] = vertex_a_x_i;
  assign va[1] = vertex_a_y_i;
  assign va[2] = vertex_a_z_i;
  assign vb[0] = vertex_b_x_i;
  assign vb[1] = vertex_b_y_i;
  assign vb[2] = vertex_b_z_i;
  assign vc[0] = vertex_c_x_i;
  assign vc[1] = vertex_c_y_i;
  assign vc[2] = vertex_c_z_i;
  assign vp[0] = point_x_i;
  assign vp[1] = point_y_i;
  assign vp[2] = point_z_i;

  logic signed [COORD_WIDTH-1:0] e_s [NumEdges][NumAxes];
  logic signed [COORD_WIDTH-1:0] f_s [NumEdges][NumAxes];
  logic signed [COORD_WIDTH-1:0] o_s [NumEdges][NumAxes];

  always_comb begin
    for (int i = 0; i < NumAxes; i++) begin
      e_s[0][i] = vb[i];
      f_s[0][i] = vc[i];
      o_s[0][i] = va[i];
      e_s[1][i] = va[i];
      f_s[1][i] = vc[i];
      o_s[1][i] = vb[i];
      e_s[2][i] = va[i];
      f_s[2][i] = vb[i];
      o_s[2][i] = vc[i];
    end
  end

  // stage 0: differences
  logic signed [DW-1:0] d_q [NumEdges][NumAxes];
  logic signed [DW-1:0] p_q [NumEdges][NumAxes];
  logic signed [DW-1:0] o_q [NumEdges][NumAxes];

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      for (int k = 0; k < NumEdges; k++) begin
        for (int i = 0; i < NumAxes; i++) begin
          d_q[k][i] <= DW'(f_s[k][i]) - DW'(e_s[k][i]);
          p_q[k][i] <= DW'(vp[i]) - DW'(e_s[k][i]);
          o_q[k][i] <= DW'(o_s[k][i]) - DW'(e_s[k][i]);
        end
      end
    end
  end

  // stage 1: cross product terms
  logic signed [PW-1:0] ut0_q [NumEdges][NumAxes];
  logic signed [PW-1:0] ut1_q [NumEdges][NumAxes];
  logic signed [PW-1:0] vt0_q [NumEdges][NumAxes];
  logic signed [PW-1:0] vt1_q [NumEdges][NumAxes];

  always_ff @(posedge clk_i) begin
    int j;
    int m;
    if (rdy[1]) begin
      for (int k = 0; k < NumEdges; k++) begin
        for (int i = 0; i < NumAxes; i++) begin
          j = (i == 2) ? 0 : i + 1;
          m = (i == 0) ? 2 : i - 1;
          ut0_q[k][i] <= PW'(d_q[k][j]) * PW'(p_q[k][m]);
          ut1_q[k][i] <= PW'(d_q[k][m]) * PW'(p_q[k][j]);
          vt0_q[k][i] <= PW'(d_q[k][j]) * PW'(o_q[k][m]);
          vt1_q[k][i] <= PW'(d_q[k][m]) * PW'(o_q[k][j]);
        end
      end
    end
  end

  // stage 2: cross product components
  logic signed [CW-1:0] u_q [NumEdges][NumAxes];
  logic signed [CW-1:0] v_q [NumEdges][NumAxes];

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      for (int k = 0; k < NumEdges; k++) begin
        for (int i = 0; i < NumAxes; i++) begin
          u_q[k][i] <= CW'(ut0_q[k][i]) - CW'(ut1_q[k][i]);
          v_q[k][i] <= CW'(vt0_q[k][i]) - CW'(vt1_q[k][i]);
        end
      end
    end
  end

  // stage 3: split dot terms into half-width partial products
  logic        [LLW-1:0] ll_q [NumEdges][NumAxes];
  logic signed [MW-1:0]  lh_q [NumEdges][NumAxes];
  logic signed [MW-1:0]  hl_q [NumEdges][NumAxes];
  logic signed [HHW-1:0] hh_q [NumEdges][NumAxes];

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      for (int k = 0; k < NumEdges; k++) begin
        for (int i = 0; i < NumAxes; i++) begin
          ll_q[k][i] <= LLW'(u_q[k][i][LW-1:0]) * LLW'(v_q[k][i][LW-1:0]);
          lh_q[k][i] <= MW'($signed({1'b0, u_q[k][i][LW-1:0]}))
                      * MW'($signed(v_q[k][i][CW-1:LW]));
          hl_q[k][i] <= MW'($signed(u_q[k][i][CW-1:LW]))
                      * MW'($signed({1'b0, v_q[k][i][LW-1:0]}));
          hh_q[k][i] <= HHW'($signed(u_q[k][i][CW-1:LW]))
                      * HHW'($signed(v_q[k][i][CW-1:LW]));
        end
      end
    end
  end

  // stage 4: recombine partials
  logic signed [QW-1:0] prod_q [NumEdges][NumAxes];

  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      for (int k = 0; k < NumEdges; k++) begin
        for (int i = 0; i < NumAxes; i++) begin
          prod_q[k][i] <= QW'($signed({1'b0, ll_q[k][i]}))
                        + (QW'(lh_q[k][i]) <<< LW)
                        + (QW'(hl_q[k][i]) <<< LW)
                        + (QW'(hh_q[k][i]) <<< (2 * LW));
        end
      end
    end
  end

  // stage 5: dot sum plus tolerance, sign test per edge
  logic signed [SW-1:0]       dot_s [NumEdges];
  logic        [NumEdges-1:0] pass_s;
  logic                       inside_q;

  always_comb begin
    for (int k = 0; k < NumEdges; k++) begin
      dot_s[k] = SW'(prod_q[k][0]) + SW'(prod_q[k][1]) + SW'(prod_q[k][2])
               + SW'($signed({1'b0, tol_q}));
      pass_s[k] = ~dot_s[k][SW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[5]) begin
      inside_q <= &pass_s;
    end
  end

  assign out_valid_o  = valid_q[PipeDepth-1];
  assign inside_res_o = inside_q;

endmodule

>>> hdl/pit_checker.sv
// ----------------------------------------------------------------------------
// pit_checker
// Port-level checks for the point-in-triangle test pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pit_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic inside_res_o
);

  import pit_pkg::*;

  localparam int unsigned CntW = $clog2(PipeDepth + 1) + 1;

  logic [CntW-1:0] cnt_q;
  logic [CntW-1:0] cnt_d;
  logic            in_xact;
  logic            out_xact;

  assign in_xact  = in_valid_i & in_ready_o;
  assign out_xact = out_valid_o & out_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (in_xact && !out_xact) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!in_xact && out_xact) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(inside_res_o))
    else $error("stalled result changed");

  // an empty output register never blocks the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o || out_ready_i |-> in_ready_o)
    else $error("input stalled without downstream backpressure");

  // no more transactions in flight than stages
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(PipeDepth))
    else $error("pipeline occupancy exceeded");

  // no result without an outstanding input transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == '0 |-> !out_valid_o)
    else $error("result without input transaction");

endmodule

bind point_in_triangle_test pit_checker u_pit_checker (.*);
